/* sv/esa_pkg.sv */
// Package for the entity slot allocator: field widths, command and status codes,
// and the payload structs of the command and result channels. It depends on nothing.
`default_nettype none
package esa_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned MASK_W = 32;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SLOTS_FULL = 3'd1,
    ST_ARCH_FULL  = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_SLOT_EMPTY = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [MASK_W-1:0]  archetype_mask;
    logic [IDX_W-1:0]   slot_index;
    logic [IDX_W-1:0]   member_index;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   slot;
    logic [IDX_W-1:0]   assigned_member;
    logic               moved_valid;
    logic [IDX_W-1:0]   moved_slot;
  } res_t;

endpackage
`default_nettype wire

/* sv/esa_if.sv */
// Valid/ready channel interfaces for the command and result sides of the allocator.
// They depend on esa_pkg for the payload structs.
`default_nettype none
interface esa_in_if;
  logic          valid;
  logic          ready;
  esa_pkg::cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface esa_out_if;
  logic          valid;
  logic          ready;
  esa_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/entity_slot_allocator_unit.sv */
// Entity slot allocator: slot table and archetype registry held in two
// synchronous memories, driven by a read-modify-write sequencer.
// Depends on esa_pkg and the channel interfaces in esa_if.sv.
//
// Commands arrive as transactions on in_ch (create, delete, find, clear) and
// each gives exactly one result transaction on out_ch. One command is worked
// on at a time; in_ch is ready whenever the sequencer is idle, even while the
// previous result still waits in the output register.
// A clear, and a command rejected on its inputs alone, go straight to the
// result state. A create scans the archetype memory (one entry a cycle, up
// to the number registered) and, when it fills a gap, the slot memory from
// that gap up to the end of the used region. A delete reads its slot, scans
// the archetype memory, and may scan the slot memory once to find the entity
// to renumber. A find scans the slot memory. Each scan reads one entry a
// cycle from the single read port of its memory.
// Reset clears the counters and the sequencer at once; the memories need no
// clearing pass, as no entry is read before a command has written it.
// If the receiver stalls, the result stays in the output register and the
// next finished result waits in the sequencer until the register is free.
`default_nettype none
module entity_slot_allocator_unit #(
  parameter int unsigned ENTITY_SLOTS    = 1024,
  parameter int unsigned ARCHETYPE_SLOTS = 32,
  parameter int unsigned MASK_BITS       = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  esa_in_if.sink     in_ch,
  esa_out_if.source  out_ch
);

  localparam int unsigned SW  = $clog2(ENTITY_SLOTS);
  localparam int unsigned SCW = $clog2(ENTITY_SLOTS + 1);
  localparam int unsigned AW  = $clog2(ARCHETYPE_SLOTS);
  localparam int unsigned ACW = $clog2(ARCHETYPE_SLOTS + 1);
  localparam int unsigned XW  = (SCW > ACW) ? SCW : ACW;
  localparam int unsigned CW  = (SCW > esa_pkg::IDX_W) ? SCW : esa_pkg::IDX_W;
  localparam int unsigned DW  = MASK_BITS + SCW;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DCHK  = 7'b0000010,
    S_ALOOK = 7'b0000100,
    S_CRE   = 7'b0001000,
    S_SSCAN = 7'b0010000,
    S_DFIN  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  // Each memory entry holds a mask and a count or member index.
  logic [DW-1:0] slot_mem [ENTITY_SLOTS];
  logic [DW-1:0] arch_mem [ARCHETYPE_SLOTS];
  logic [DW-1:0] slot_rdata_r, arch_rdata_r;

  logic          slot_we, arch_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [AW-1:0] arch_waddr, arch_raddr;
  logic [DW-1:0] slot_wdata, arch_wdata;

  state_t               state_r, state_nxt;
  esa_pkg::opcode_t     opc_r, opc_nxt;
  logic [MASK_BITS-1:0] mask_r, mask_nxt;
  logic [CW-1:0]        sidx_r, sidx_nxt, midx_r, midx_nxt;
  logic [SCW-1:0]       own_r, own_nxt, newlen_r, newlen_nxt, acnt_r, acnt_nxt;
  logic                 found_r, found_nxt;
  logic [AW-1:0]        a_r, a_nxt;
  logic [XW-1:0]        scan_r, scan_nxt, chk_r, chk_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [SCW-1:0]       used_end_r, used_end_nxt, gap_total_r, gap_total_nxt;
  logic [SCW-1:0]       lowest_gap_r, lowest_gap_nxt;
  logic [ACW-1:0]       total_r, total_nxt;
  esa_pkg::status_t     res_status_r, res_status_nxt;
  logic [SW-1:0]        res_slot_r, res_slot_nxt, res_mslot_r, res_mslot_nxt;
  logic [SCW-1:0]       res_amem_r, res_amem_nxt;
  logic                 res_mv_r, res_mv_nxt;
  logic                 out_valid_r, out_valid_nxt;
  esa_pkg::res_t        out_data_r, out_data_nxt;

  logic [MASK_BITS-1:0] in_mask, s_mask, a_mask;
  logic [SCW-1:0]       s_mem, a_cnt, sel_cnt;
  logic [SW-1:0]        sel_slot;
  logic [AW-1:0]        sel_arch;
  logic [XW-1:0]        scan_limit;
  logic                 can_issue, has_gap;
  logic [CW-1:0]        slot_wide, mslot_wide, amem_wide;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_r <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk) begin
    if (arch_we) begin
      arch_mem[arch_waddr] <= arch_wdata;
    end
    arch_rdata_r <= arch_mem[arch_raddr];
  end

  assign in_mask = MASK_BITS'(in_ch.data.archetype_mask);
  assign s_mask  = slot_rdata_r[DW-1:SCW];
  assign s_mem   = slot_rdata_r[SCW-1:0];
  assign a_mask  = arch_rdata_r[DW-1:SCW];
  assign a_cnt   = arch_rdata_r[SCW-1:0];
  assign has_gap = (gap_total_r != '0) && (lowest_gap_r < SCW'(ENTITY_SLOTS));

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    opc_nxt        = opc_r;
    mask_nxt       = mask_r;
    sidx_nxt       = sidx_r;
    midx_nxt       = midx_r;
    own_nxt        = own_r;
    newlen_nxt     = newlen_r;
    acnt_nxt       = acnt_r;
    found_nxt      = found_r;
    a_nxt          = a_r;
    scan_nxt       = scan_r;
    chk_nxt        = chk_r;
    chk_vld_nxt    = chk_vld_r;
    used_end_nxt   = used_end_r;
    gap_total_nxt  = gap_total_r;
    lowest_gap_nxt = lowest_gap_r;
    total_nxt      = total_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_mslot_nxt  = res_mslot_r;
    res_amem_nxt   = res_amem_r;
    res_mv_nxt     = res_mv_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    slot_we        = 1'b0;
    arch_we        = 1'b0;
    slot_waddr     = '0;
    arch_waddr     = '0;
    slot_wdata     = '0;
    arch_wdata     = '0;
    slot_raddr     = scan_r[SW-1:0];
    arch_raddr     = scan_r[AW-1:0];
    sel_cnt        = found_r ? acnt_r : '0;
    sel_arch       = found_r ? a_r : total_r[AW-1:0];
    sel_slot       = has_gap ? lowest_gap_r[SW-1:0] : used_end_r[SW-1:0];
    scan_limit     = (state_r == S_ALOOK) ? XW'(total_r) : XW'(used_end_r);
    can_issue      = (scan_r < scan_limit);
    slot_wide      = CW'(res_slot_r);
    mslot_wide     = CW'(res_mslot_r);
    amem_wide      = CW'(res_amem_r);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // Scans issue one read a cycle and check the entry read in the cycle before.
    if (state_r == S_ALOOK || state_r == S_SSCAN) begin
      if (can_issue) begin
        scan_nxt    = scan_r + XW'(1);
        chk_nxt     = scan_r;
        chk_vld_nxt = 1'b1;
      end else begin
        chk_vld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        slot_raddr = SW'(in_ch.data.slot_index);
        if (in_ch.valid) begin
          opc_nxt        = in_ch.data.opcode;
          mask_nxt       = in_mask;
          sidx_nxt       = CW'(in_ch.data.slot_index);
          midx_nxt       = CW'(in_ch.data.member_index);
          res_status_nxt = esa_pkg::ST_OK;
          res_slot_nxt   = '0;
          res_mslot_nxt  = '0;
          res_amem_nxt   = '0;
          res_mv_nxt     = 1'b0;
          scan_nxt       = '0;
          chk_vld_nxt    = 1'b0;
          found_nxt      = 1'b0;
          unique case (in_ch.data.opcode)
            esa_pkg::OP_CREATE: begin
              if (in_mask == '0) begin
                res_status_nxt = esa_pkg::ST_NOT_FOUND;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_ALOOK;
              end
            end
            esa_pkg::OP_DELETE: begin
              if (CW'(in_ch.data.slot_index) >= CW'(used_end_r) ||
                  CW'(in_ch.data.slot_index) >= CW'(ENTITY_SLOTS)) begin
                res_status_nxt = esa_pkg::ST_SLOT_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_DCHK;
              end
            end
            esa_pkg::OP_FIND: begin
              res_status_nxt = esa_pkg::ST_NOT_FOUND;
              state_nxt      = (in_mask == '0) ? S_DONE : S_SSCAN;
            end
            esa_pkg::OP_CLEAR: begin
              used_end_nxt   = '0;
              gap_total_nxt  = '0;
              lowest_gap_nxt = SCW'(ENTITY_SLOTS);
              total_nxt      = '0;
              state_nxt      = S_DONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_DCHK: begin
        if (s_mask == '0) begin
          res_status_nxt = esa_pkg::ST_SLOT_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          mask_nxt  = s_mask;
          own_nxt   = s_mem;
          state_nxt = S_ALOOK;
        end
      end

      S_ALOOK: begin
        if (chk_vld_r && a_mask == mask_r) begin
          found_nxt = 1'b1;
          a_nxt     = chk_r[AW-1:0];
          acnt_nxt  = a_cnt;
          if (opc_r == esa_pkg::OP_CREATE) begin
            state_nxt = S_CRE;
          end else begin
            // The freed member index is taken by the holder of the last one.
            newlen_nxt  = a_cnt - SCW'(1);
            arch_we     = 1'b1;
            arch_waddr  = chk_r[AW-1:0];
            arch_wdata  = {mask_r, a_cnt - SCW'(1)};
            scan_nxt    = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = (own_r != a_cnt - SCW'(1)) ? S_SSCAN : S_DFIN;
          end
        end else if (!chk_vld_r && !can_issue) begin
          if (opc_r == esa_pkg::OP_CREATE) begin
            state_nxt = S_CRE;
          end else begin
            res_status_nxt = esa_pkg::ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end

      S_CRE: begin
        if (!found_r && total_r >= ACW'(ARCHETYPE_SLOTS)) begin
          res_status_nxt = esa_pkg::ST_ARCH_FULL;
          state_nxt      = S_DONE;
        end else if (!has_gap && used_end_r >= SCW'(ENTITY_SLOTS)) begin
          res_status_nxt = esa_pkg::ST_SLOTS_FULL;
          state_nxt      = S_DONE;
        end else begin
          if (!found_r) begin
            total_nxt = total_r + ACW'(1);
          end
          arch_we      = 1'b1;
          arch_waddr   = sel_arch;
          arch_wdata   = {mask_r, sel_cnt + SCW'(1)};
          slot_we      = 1'b1;
          slot_waddr   = sel_slot;
          slot_wdata   = {mask_r, sel_cnt};
          res_slot_nxt = sel_slot;
          res_amem_nxt = sel_cnt;
          if (has_gap) begin
            // Look for the next free slot above the one just filled.
            gap_total_nxt = gap_total_r - SCW'(1);
            scan_nxt      = XW'(lowest_gap_r) + XW'(1);
            chk_vld_nxt   = 1'b0;
            state_nxt     = S_SSCAN;
          end else begin
            used_end_nxt = used_end_r + SCW'(1);
            state_nxt    = S_DONE;
          end
        end
      end

      S_SSCAN: begin
        unique case (opc_r)
          esa_pkg::OP_CREATE: begin
            if (chk_vld_r && s_mask == '0) begin
              lowest_gap_nxt = SCW'(chk_r);
              state_nxt      = S_DONE;
            end else if (!chk_vld_r && !can_issue) begin
              lowest_gap_nxt = SCW'(ENTITY_SLOTS);
              state_nxt      = S_DONE;
            end
          end
          esa_pkg::OP_DELETE: begin
            if (chk_vld_r && SW'(chk_r) != sidx_r[SW-1:0] && s_mask == mask_r &&
                s_mem == newlen_r) begin
              slot_we       = 1'b1;
              slot_waddr    = SW'(chk_r);
              slot_wdata    = {mask_r, own_r};
              res_mv_nxt    = 1'b1;
              res_mslot_nxt = SW'(chk_r);
              state_nxt     = S_DFIN;
            end else if (!chk_vld_r && !can_issue) begin
              state_nxt = S_DFIN;
            end
          end
          esa_pkg::OP_FIND: begin
            if (chk_vld_r && s_mask == mask_r && CW'(s_mem) == midx_r) begin
              res_status_nxt = esa_pkg::ST_OK;
              res_slot_nxt   = SW'(chk_r);
              state_nxt      = S_DONE;
            end else if (!chk_vld_r && !can_issue) begin
              state_nxt = S_DONE;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end

      S_DFIN: begin
        slot_we    = 1'b1;
        slot_waddr = sidx_r[SW-1:0];
        slot_wdata = '0;
        if (CW'(used_end_r) == sidx_r + CW'(1)) begin
          used_end_nxt = used_end_r - SCW'(1);
        end else begin
          gap_total_nxt = gap_total_r + SCW'(1);
          if (CW'(lowest_gap_r) > sidx_r) begin
            lowest_gap_nxt = SCW'(sidx_r);
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt                = 1'b1;
          out_data_nxt.status          = res_status_r;
          out_data_nxt.slot            = slot_wide[esa_pkg::IDX_W-1:0];
          out_data_nxt.assigned_member = amem_wide[esa_pkg::IDX_W-1:0];
          out_data_nxt.moved_valid     = res_mv_r;
          out_data_nxt.moved_slot      = mslot_wide[esa_pkg::IDX_W-1:0];
          state_nxt                    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      chk_vld_r    <= 1'b0;
      used_end_r   <= '0;
      gap_total_r  <= '0;
      lowest_gap_r <= SCW'(ENTITY_SLOTS);
      total_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      used_end_r   <= used_end_nxt;
      gap_total_r  <= gap_total_nxt;
      lowest_gap_r <= lowest_gap_nxt;
      total_r      <= total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opc_r        <= opc_nxt;
    mask_r       <= mask_nxt;
    sidx_r       <= sidx_nxt;
    midx_r       <= midx_nxt;
    own_r        <= own_nxt;
    newlen_r     <= newlen_nxt;
    acnt_r       <= acnt_nxt;
    found_r      <= found_nxt;
    a_r          <= a_nxt;
    scan_r       <= scan_nxt;
    chk_r        <= chk_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_mslot_r  <= res_mslot_nxt;
    res_amem_r   <= res_amem_nxt;
    res_mv_r     <= res_mv_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
`default_nettype wire

/* verif/entity_slot_allocator_unit_test.sv */
// Self-checking testbench for entity_slot_allocator_unit: directed and random commands,
// results predicted by a behavioural copy of the slot table and archetype registry.
// Depends on esa_pkg and the channel interfaces in esa_if.sv.
`default_nettype none
module entity_slot_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 1024;
  localparam int NARCH  = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esa_in_if  in_ch ();
  esa_out_if out_ch ();

  entity_slot_allocator_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Behavioural copy of the allocator state.
  logic [31:0] tbl_mask [NSLOTS];
  logic [9:0]  tbl_member [NSLOTS];
  logic [31:0] reg_mask [NARCH];
  int          reg_count [NARCH];
  int          reg_total, used_end, live_total, gap_total, lowest_gap;

  esa_pkg::cmd_t pending_cmds [$];
  esa_pkg::res_t expected_results [$];
  int   errors = 0;
  int   accepted = 0;
  int   checked = 0;
  int   status_seen [5];

  function automatic void clear_tables();
    for (int i = 0; i < NSLOTS; i++) begin
      tbl_mask[i] = '0;
      tbl_member[i] = '0;
    end
    for (int i = 0; i < NARCH; i++) begin
      reg_mask[i] = '0;
      reg_count[i] = 0;
    end
    reg_total = 0;
    used_end = 0;
    live_total = 0;
    gap_total = 0;
    lowest_gap = NSLOTS;
  endfunction

  function automatic int find_archetype(logic [31:0] m);
    for (int i = 0; i < reg_total; i++)
      if (reg_mask[i] == m) return i;
    return -1;
  endfunction

  function automatic esa_pkg::res_t allocate_slot(esa_pkg::cmd_t c);
    esa_pkg::res_t r;
    int a, s, own, newlen;
    bit has_gap;
    r = '0;
    r.status = esa_pkg::ST_OK;
    case (c.opcode)
      esa_pkg::OP_CREATE: begin
        a = find_archetype(c.archetype_mask);
        has_gap = gap_total != 0 && lowest_gap < NSLOTS;
        if (c.archetype_mask == '0) begin
          r.status = esa_pkg::ST_NOT_FOUND;
        end else if (a < 0 && reg_total >= NARCH) begin
          r.status = esa_pkg::ST_ARCH_FULL;
        end else if (!has_gap && used_end >= NSLOTS) begin
          r.status = esa_pkg::ST_SLOTS_FULL;
        end else begin
          if (a < 0) begin
            a = reg_total;
            reg_mask[a] = c.archetype_mask;
            reg_count[a] = 0;
            reg_total++;
          end
          if (has_gap) begin
            s = lowest_gap;
            gap_total--;
            lowest_gap = NSLOTS;
            for (int i = s + 1; i < used_end; i++)
              if (tbl_mask[i] == '0) begin
                lowest_gap = i;
                break;
              end
          end else begin
            s = used_end;
            used_end++;
          end
          tbl_mask[s] = c.archetype_mask;
          tbl_member[s] = 10'(reg_count[a]);
          r.slot = 10'(s);
          r.assigned_member = 10'(reg_count[a]);
          reg_count[a]++;
          live_total++;
        end
      end
      esa_pkg::OP_DELETE: begin
        s = c.slot_index;
        if (s >= used_end || tbl_mask[s] == '0) begin
          r.status = esa_pkg::ST_SLOT_EMPTY;
        end else begin
          a = find_archetype(tbl_mask[s]);
          if (a < 0) begin
            r.status = esa_pkg::ST_NOT_FOUND;
          end else begin
            own = tbl_member[s];
            newlen = reg_count[a] - 1;
            reg_count[a] = newlen;
            if (own != newlen) begin
              for (int i = 0; i < used_end; i++)
                if (i != s && tbl_mask[i] == tbl_mask[s] && tbl_member[i] == newlen) begin
                  tbl_member[i] = 10'(own);
                  r.moved_valid = 1'b1;
                  r.moved_slot = 10'(i);
                  break;
                end
            end
            tbl_mask[s] = '0;
            tbl_member[s] = '0;
            live_total--;
            if (s + 1 == used_end) begin
              used_end--;
            end else begin
              gap_total++;
              if (s < lowest_gap) lowest_gap = s;
            end
          end
        end
      end
      esa_pkg::OP_FIND: begin
        r.status = esa_pkg::ST_NOT_FOUND;
        if (c.archetype_mask != '0) begin
          for (int i = 0; i < used_end; i++)
            if (tbl_mask[i] == c.archetype_mask && tbl_member[i] == c.member_index) begin
              r.status = esa_pkg::ST_OK;
              r.slot = 10'(i);
              break;
            end
        end
      end
      default: clear_tables();
    endcase
    return r;
  endfunction

  // Idling pattern changes every 150 accepted commands.
  function automatic int idle_percent(bit receiver);
    case ((accepted / 150) % 4)
      1: return receiver ? 0 : 45;
      2: return receiver ? 45 : 0;
      3: return 35;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      next_valid = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(allocate_slot(in_ch.data));
        accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_cmds.size() != 0 &&
          $urandom_range(99) >= idle_percent(1'b0)) begin
        in_ch.data <= pending_cmds.pop_front();
        next_valid = 1'b1;
      end
      in_ch.valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    esa_pkg::res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no command outstanding: %p", out_ch.data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (out_ch.data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
            errors++;
          end
          if (out_ch.data.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_ch.data.slot);
            errors++;
          end
          if (out_ch.data.assigned_member !== want.assigned_member) begin
            $error("assigned_member: expected %0d, got %0d",
                   want.assigned_member, out_ch.data.assigned_member);
            errors++;
          end
          if (out_ch.data.moved_valid !== want.moved_valid) begin
            $error("moved_valid: expected %0d, got %0d",
                   want.moved_valid, out_ch.data.moved_valid);
            errors++;
          end
          if (out_ch.data.moved_slot !== want.moved_slot) begin
            $error("moved_slot: expected %0d, got %0d", want.moved_slot, out_ch.data.moved_slot);
            errors++;
          end
          if (want.status <= esa_pkg::ST_SLOT_EMPTY) status_seen[want.status]++;
        end
      end
      out_ch.ready <= $urandom_range(99) >= idle_percent(1'b1);
    end
  end

  function automatic void queue_cmd(esa_pkg::opcode_t op, logic [31:0] m, int s, int mi);
    esa_pkg::cmd_t c;
    c.opcode = op;
    c.archetype_mask = m;
    c.slot_index = 10'(s);
    c.member_index = 10'(mi);
    pending_cmds.push_back(c);
  endfunction

  initial begin
    logic [31:0] pool [8];
    int pick;
    clear_tables();
    for (int i = 0; i < 5; i++) status_seen[i] = 0;
    for (int i = 0; i < 8; i++) pool[i] = $urandom() | 32'h1;

    // Directed: invalid masks, relocation, gap refill, extremes of the fields.
    queue_cmd(esa_pkg::OP_CREATE, 32'h0, 0, 0);
    queue_cmd(esa_pkg::OP_FIND, 32'h0, 0, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h1, 1023, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'h8000_0000, 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(esa_pkg::OP_FIND, 32'hFFFF_FFFF, 0, 2);
    queue_cmd(esa_pkg::OP_FIND, 32'hFFFF_FFFF, 0, 1023);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 0, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 0, 0);
    queue_cmd(esa_pkg::OP_FIND, 32'hFFFF_FFFF, 0, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 3, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'h8000_0000, 1023, 1023);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 0, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 1023, 0);
    queue_cmd(esa_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1023, 1023);
    queue_cmd(esa_pkg::OP_FIND, 32'h8000_0000, 0, 0);

    // Fill a short region, punch gaps in it, then refill them lowest first.
    for (int i = 0; i < 12; i++) queue_cmd(esa_pkg::OP_CREATE, pool[i % 3], 0, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 5, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 3, 0);
    queue_cmd(esa_pkg::OP_DELETE, 32'h0, 11, 0);
    queue_cmd(esa_pkg::OP_FIND, pool[1], 0, 3);
    queue_cmd(esa_pkg::OP_CREATE, pool[2], 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, pool[2], 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, pool[2], 0, 0);
    queue_cmd(esa_pkg::OP_CLEAR, 32'h0, 0, 0);

    // Fill the archetype registry, try one more new mask, then reuse a known one.
    for (int i = 0; i < NARCH; i++) queue_cmd(esa_pkg::OP_CREATE, 32'h1 << i, 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'h3, 0, 0);
    queue_cmd(esa_pkg::OP_CREATE, 32'h1, 0, 0);
    queue_cmd(esa_pkg::OP_CLEAR, 32'h0, 0, 0);

    // Random traffic, mostly against a small set of archetypes and a small slot region.
    for (int n = 0; n < 507; n++) begin
      pick = $urandom_range(999);
      if (pick < 15) begin
        queue_cmd(esa_pkg::OP_CLEAR, $urandom(), $urandom_range(1023), $urandom_range(1023));
      end else if (pick < 480) begin
        queue_cmd(esa_pkg::OP_CREATE,
                  $urandom_range(99) < 6 ? $urandom() : pool[$urandom_range(7)],
                  $urandom_range(1023), $urandom_range(1023));
      end else if (pick < 780) begin
        queue_cmd(esa_pkg::OP_DELETE, $urandom(),
                  $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(47),
                  $urandom_range(1023));
      end else begin
        queue_cmd(esa_pkg::OP_FIND,
                  $urandom_range(19) == 0 ? $urandom() : pool[$urandom_range(7)],
                  $urandom_range(1023),
                  $urandom_range(9) == 0 ? $urandom_range(1023) : $urandom_range(15));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_cmds.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (1200) @(posedge clk);
    $display("Ran %0d commands, %0d results checked, %0d failures.", accepted, checked, errors);
    $display("Status mix: ok %0d, slots full %0d, registry full %0d, not found %0d, empty %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
